>>> hdl/rmsbr_pkg.sv
package rmsbr_pkg;

  // Field and state widths
  localparam int SAMPLE_W   = 8;
  localparam int SQUARE_W   = 2 * SAMPLE_W;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 13;
  localparam int OFFSET_W   = 8;
  localparam int GAIN_W     = 12;
  localparam int RMS_W      = 12;
  localparam int BRIGHT_W   = 9;
  localparam int FRAC_SHIFT = 8;
  localparam int RMS_FRAC   = 4;
  localparam int DIVIDEND_W = SUM_W + FRAC_SHIFT;
  localparam int PROD_W     = RMS_W + GAIN_W;
  localparam int ROOT_REM_W = RMS_W + 3;
  localparam int ITER_W     = 6;

  // Frame limit and result limits
  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam int RMS_MAX           = 4080;
  localparam int BRIGHT_MAX        = 256;

  // Iteration counts of the shared divide and root steps
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int ROOT_STEPS = RMS_W;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q12     = 1'b1;
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET     = 8'd145;
  localparam logic [GAIN_W-1:0]    GAIN_RESET       = 12'd205;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_SCALE
  } rmsbr_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_en;
    logic frame_end;
    logic div_step;
    logic root_step;
    logic out_load;
  } rmsbr_cmd_t;

endpackage

>>> hdl/rms_level_to_brightness_unit.sv
// Frame RMS level meter. Unsigned PCM bytes stream in, one per cycle unless
// stalled, and are squared and summed; the byte flagged in_last_sample closes
// the frame and yields one result: rms_q4 = floor(sqrt(sum * 256 / count)),
// and brightness_q8 = (rms_q4 - 16 * level_offset) * gain_q12 / 256, clamped
// to 0..256. Bytes past 4096 in one frame are not counted. The frame-end
// computation runs on a shared restoring divider and a bit-serial square
// root, then a scale state, so out_valid rises once the DIV, ROOT and SCALE
// states have run after the edge that takes the last byte, later while an
// earlier result is still stalled in the output register. Bytes of the next
// frame are accepted meanwhile; only its closing byte is stalled until the
// previous frame's result has moved into the output register.
// Configuration writes (cfg_ready always high) belong while the block is idle.
module rms_level_to_brightness_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmsbr_pkg::SAMPLE_W-1:0]      in_sample_byte,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rmsbr_pkg::BRIGHT_W-1:0]      out_brightness_q8,
  output logic [rmsbr_pkg::RMS_W-1:0]         out_rms_q4,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmsbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmsbr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rmsbr_pkg::*;

  rmsbr_cmd_t cmd;

  assign cfg_ready = 1'b1;

  rmsbr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd)
  );

  rmsbr_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_sample_byte    (in_sample_byte),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_brightness_q8 (out_brightness_q8),
    .out_rms_q4        (out_rms_q4)
  );

endmodule

>>> hdl/rmsbr_ctrl.sv
module rmsbr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_sample,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rmsbr_pkg::rmsbr_cmd_t cmd
);
  import rmsbr_pkg::*;

  rmsbr_state_t      state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  // A frame end waits while the divide/root unit is busy; plain bytes never wait
  assign in_stall  = in_last_sample && (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Hold state, counter and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    cmd           = '0;
    cmd.acc_en    = accept;
    cmd.frame_end = accept && in_last_sample;
    case (state_r)
      ST_IDLE: begin
        iter_nxt = '0;
        if (cmd.frame_end) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (iter_r == ITER_W'(DIV_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_ROOT;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (iter_r == ITER_W'(ROOT_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_SCALE;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_SCALE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output flag: set on load, drop on transfer
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

>>> hdl/rmsbr_datapath.sv
module rmsbr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rmsbr_pkg::rmsbr_cmd_t                 cmd,
  input  logic [rmsbr_pkg::SAMPLE_W-1:0]        in_sample_byte,
  input  logic                                  cfg_we,
  input  logic [rmsbr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmsbr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [rmsbr_pkg::BRIGHT_W-1:0]        out_brightness_q8,
  output logic [rmsbr_pkg::RMS_W-1:0]           out_rms_q4
);
  import rmsbr_pkg::*;

  logic [OFFSET_W-1:0]   offset_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      count_r;
  logic [DIVIDEND_W-1:0] work_r;
  logic [CNT_W-1:0]      divisor_r;
  logic [CNT_W-1:0]      div_rem_r;
  logic [ROOT_REM_W-1:0] root_rem_r;
  logic [RMS_W-1:0]      root_r;
  logic [BRIGHT_W-1:0]   bright_r;
  logic [RMS_W-1:0]      rms_r;

  logic [SQUARE_W-1:0]   square;
  logic                  room;
  logic [SUM_W-1:0]      sum_after;
  logic [CNT_W-1:0]      count_after;
  logic [CNT_W:0]        div_trial;
  logic                  div_ge;
  logic [CNT_W:0]        div_diff;
  logic [ROOT_REM_W-1:0] root_shift;
  logic [ROOT_REM_W-1:0] root_trial;
  logic                  root_ge;
  logic [RMS_W-1:0]      rms_clamped;
  logic [RMS_W-1:0]      base;
  logic [RMS_W-1:0]      diff;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-FRAC_SHIFT-1:0] scaled;
  logic [BRIGHT_W-1:0]   bright_c;

  // Accumulate squares until the frame limit
  assign square      = in_sample_byte * in_sample_byte;
  assign room        = count_r < CNT_W'(MAX_FRAME_SAMPLES);
  assign sum_after   = room ? sum_r + SUM_W'(square) : sum_r;
  assign count_after = room ? count_r + 1'b1 : count_r;

  // Restoring divide: one quotient bit per step
  assign div_trial = {div_rem_r, work_r[DIVIDEND_W-1]};
  assign div_ge    = div_trial >= {1'b0, divisor_r};
  assign div_diff  = div_trial - {1'b0, divisor_r};

  // Digit-by-digit square root: one root bit per step
  assign root_shift = {root_rem_r[ROOT_REM_W-3:0], work_r[2*RMS_W-1 -: 2]};
  assign root_trial = {1'b0, root_r, 2'b01};
  assign root_ge    = root_shift >= root_trial;

  // Scale rms into clamped brightness
  assign rms_clamped = (root_r > RMS_W'(RMS_MAX)) ? RMS_W'(RMS_MAX) : root_r;
  assign base        = {offset_r, {RMS_FRAC{1'b0}}};
  assign diff        = (rms_clamped > base) ? rms_clamped - base : '0;
  assign prod        = diff * gain_r;
  assign scaled      = prod[PROD_W-1:FRAC_SHIFT];
  assign bright_c    = (scaled > (PROD_W-FRAC_SHIFT)'(BRIGHT_MAX)) ?
                       BRIGHT_W'(BRIGHT_MAX) : scaled[BRIGHT_W-1:0];

  // Configuration registers and frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      gain_r   <= GAIN_RESET;
      sum_r    <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEVEL_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
          CFG_GAIN_Q12:     gain_r   <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.frame_end) begin
        sum_r   <= '0;
        count_r <= '0;
      end else if (cmd.acc_en) begin
        sum_r   <= sum_after;
        count_r <= count_after;
      end
    end
  end

  // Divide and root working registers
  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      work_r     <= {sum_after, {FRAC_SHIFT{1'b0}}};
      divisor_r  <= count_after;
      div_rem_r  <= '0;
      root_rem_r <= '0;
      root_r     <= '0;
    end else if (cmd.div_step) begin
      work_r    <= {work_r[DIVIDEND_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    end else if (cmd.root_step) begin
      work_r     <= {work_r[DIVIDEND_W-3:0], 2'b00};
      root_rem_r <= root_ge ? root_shift - root_trial : root_shift;
      root_r     <= {root_r[RMS_W-2:0], root_ge};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bright_r <= bright_c;
      rms_r    <= rms_clamped;
    end
  end

  assign out_brightness_q8 = bright_r;
  assign out_rms_q4        = rms_r;

endmodule

>>> hdl/rmsbr_checker.sv
module rmsbr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_last_sample,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [rmsbr_pkg::BRIGHT_W-1:0]      out_brightness_q8,
  input logic [rmsbr_pkg::RMS_W-1:0]         out_rms_q4
);
  import rmsbr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_brightness_q8) &&
    $stable(out_rms_q4))
    else $error("stalled result changed or dropped");

  // Brightness stays within 0..1.0
  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_brightness_q8 <= BRIGHT_W'(BRIGHT_MAX))
    else $error("brightness above full scale");

  // Rms stays within the byte range
  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_q4 <= RMS_W'(RMS_MAX))
    else $error("rms above full scale");

  // Nonzero brightness needs a nonzero level
  a_bright_needs_rms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_brightness_q8 != '0) |-> out_rms_q4 != '0)
    else $error("brightness without level");

  // A closed frame keeps the next frame end waiting while math runs
  a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_sample |=> !in_last_sample || in_stall)
    else $error("frame end taken while unit busy");

endmodule

bind rms_level_to_brightness_unit rmsbr_checker u_rmsbr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_sample    (in_last_sample),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_brightness_q8 (out_brightness_q8),
  .out_rms_q4        (out_rms_q4)
);
